// ----- design/crs_pkg.sv -----
// Shared types, widths and arithmetic helpers of the CR-RC-RC pulse shaper.
package crs_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 32;
    localparam int OUT_W       = 24;
    localparam int FRAC        = ACC_BITS - OUT_W;
    localparam int XIN_PAD     = ACC_BITS - SAMPLE_BITS - FRAC;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = COEF_W + 1 + ACC_BITS;
    localparam int SUM_W       = PROD_W + 1;
    localparam int RND_W       = SUM_W - COEF_W;
    localparam int WIDE_W      = RND_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = COEF_W;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (COEF_W - 1);
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INT1_ENABLE = 3'd0,
        REG_INT1_DECAY  = 3'd1,
        REG_INT1_GAIN   = 3'd2,
        REG_DIFF_ENABLE = 3'd3,
        REG_DIFF_DECAY  = 3'd4,
        REG_INT2_ENABLE = 3'd5,
        REG_INT2_DECAY  = 3'd6,
        REG_INT2_GAIN   = 3'd7
    } cfg_idx_t;

    localparam logic [COEF_W-1:0] RST_INT1_DECAY = 16'd52016;
    localparam logic [COEF_W-1:0] RST_INT1_GAIN  = 16'd13107;
    localparam logic [COEF_W-1:0] RST_DIFF_DECAY = 16'd64236;
    localparam logic [COEF_W-1:0] RST_INT2_DECAY = 16'd62964;
    localparam logic [COEF_W-1:0] RST_INT2_GAIN  = 16'd2621;

    typedef struct packed {
        logic              int1_enable;
        logic [COEF_W-1:0] int1_decay;
        logic [COEF_W-1:0] int1_gain;
        logic              diff_enable;
        logic [COEF_W-1:0] diff_decay;
        logic              int2_enable;
        logic [COEF_W-1:0] int2_decay;
        logic [COEF_W-1:0] int2_gain;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_INT1_DECAY,
        MUL_INT1_GAIN,
        MUL_DIFF_DECAY,
        MUL_INT2_DECAY,
        MUL_INT2_GAIN
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sum_load;
        logic     f_wr;
        logic     d_wr;
        logic     s_wr;
    } dp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN1,
        ST_DDEC,
        ST_DIFF,
        ST_GAIN2,
        ST_FINAL
    } ctrl_state_t;

    // Round half up and drop the Q0.16 coefficient fraction.
    function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v + ROUND_HALF;
        return t[SUM_W-1:COEF_W];
    endfunction

    // Clamp to the signed accumulator range.
    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-ACC_BITS:0] top;
        top = v[WIDE_W-1:ACC_BITS-1];
        if ((&top) || !(|top))
            return v[ACC_BITS-1:0];
        else if (v[WIDE_W-1])
            return ACC_MIN;
        else
            return ACC_MAX;
    endfunction

endpackage

// ----- design/crs_intf.sv -----
// Channel interfaces of the pulse shaper: sample input, result output, configuration writes.
interface crs_sample_if import crs_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;

    modport source (output valid, sample, first, input ready);
    modport sink   (input valid, sample, first, output ready);
endinterface

interface crs_result_if import crs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] integrated;
    logic signed [OUT_W-1:0] differentiated;
    logic signed [OUT_W-1:0] shaped;

    modport source (output valid, integrated, differentiated, shaped, input ready);
    modport sink   (input valid, integrated, differentiated, shaped, output ready);
endinterface

interface crs_cfg_if import crs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/crs_cfg.sv -----
// Configuration register bank of the pulse shaper.
module crs_cfg import crs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    crs_cfg_if.sink cfg,
    output cfg_t   regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_INT1_ENABLE: regs_next.int1_enable = cfg.data[0];
                REG_INT1_DECAY:  regs_next.int1_decay  = cfg.data;
                REG_INT1_GAIN:   regs_next.int1_gain   = cfg.data;
                REG_DIFF_ENABLE: regs_next.diff_enable = cfg.data[0];
                REG_DIFF_DECAY:  regs_next.diff_decay  = cfg.data;
                REG_INT2_ENABLE: regs_next.int2_enable = cfg.data[0];
                REG_INT2_DECAY:  regs_next.int2_decay  = cfg.data;
                REG_INT2_GAIN:   regs_next.int2_gain   = cfg.data;
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.int1_enable <= 1'b1;
            regs_reg.int1_decay  <= RST_INT1_DECAY;
            regs_reg.int1_gain   <= RST_INT1_GAIN;
            regs_reg.diff_enable <= 1'b1;
            regs_reg.diff_decay  <= RST_DIFF_DECAY;
            regs_reg.int2_enable <= 1'b1;
            regs_reg.int2_decay  <= RST_INT2_DECAY;
            regs_reg.int2_gain   <= RST_INT2_GAIN;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- design/crs_ctrl.sv -----
// Sequencer of the pulse shaper: steps the shared multiplier and owns both handshakes.
module crs_ctrl import crs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = MUL_INT1_DECAY;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_INT1_DECAY;
                    state_next  = ST_GAIN1;
                end
            end
            ST_GAIN1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_INT1_GAIN;
                cmd.sum_load = 1'b1;
                state_next   = ST_DDEC;
            end
            ST_DDEC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DIFF_DECAY;
                cmd.f_wr    = 1'b1;
                state_next  = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INT2_DECAY;
                cmd.d_wr    = 1'b1;
                state_next  = ST_GAIN2;
            end
            ST_GAIN2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_INT2_GAIN;
                cmd.sum_load = 1'b1;
                state_next   = ST_FINAL;
            end
            ST_FINAL:
            begin
                // hold until the output register has room for the beat
                if (out_free)
                begin
                    cmd.s_wr       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/crs_dp.sv -----
// Datapath of the pulse shaper: shared 17x32 multiplier, accumulator and stage state.
module crs_dp import crs_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    input  cfg_t                          cfg,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          first,
    output logic signed [OUT_W-1:0]       integrated,
    output logic signed [OUT_W-1:0]       differentiated,
    output logic signed [OUT_W-1:0]       shaped
);

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          first_reg;
    logic signed [ACC_BITS-1:0]    int1_acc_reg;
    logic signed [ACC_BITS-1:0]    diff_acc_reg;
    logic signed [ACC_BITS-1:0]    int2_acc_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      sum_reg;
    logic signed [ACC_BITS-1:0]    f_reg;
    logic signed [ACC_BITS-1:0]    d_reg;
    logic signed [OUT_W-1:0]       integrated_reg;
    logic signed [OUT_W-1:0]       differentiated_reg;
    logic signed [OUT_W-1:0]       shaped_reg;

    logic signed [ACC_BITS-1:0]    xin;
    logic        [COEF_W-1:0]      coef;
    logic signed [COEF_W:0]        coef_s;
    logic signed [ACC_BITS-1:0]    op;
    logic signed [PROD_W-1:0]      mul_out;
    logic signed [SUM_W-1:0]       pair_sum;
    logic signed [ACC_BITS-1:0]    f_next;
    logic signed [ACC_BITS-1:0]    d_next;
    logic signed [ACC_BITS-1:0]    s_next;
    logic signed [WIDE_W-1:0]      d_wide;

    assign xin = {{XIN_PAD{x_reg[SAMPLE_BITS-1]}}, x_reg, {FRAC{1'b0}}};

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_INT1_DECAY:
            begin
                coef = cfg.int1_decay;
                // a first sample restarts from zero state
                op   = (cmd.load && first) ? '0 : int1_acc_reg;
            end
            MUL_INT1_GAIN:
            begin
                coef = cfg.int1_gain;
                op   = xin;
            end
            MUL_DIFF_DECAY:
            begin
                coef = cfg.diff_decay;
                op   = diff_acc_reg;
            end
            MUL_INT2_DECAY:
            begin
                coef = cfg.int2_decay;
                op   = int2_acc_reg;
            end
            MUL_INT2_GAIN:
            begin
                coef = cfg.int2_gain;
                op   = d_reg;
            end
            default:
            begin
                coef = '0;
                op   = '0;
            end
        endcase
    end

    assign coef_s   = {1'b0, coef};
    assign mul_out  = PROD_W'(coef_s) * PROD_W'(op);
    assign pair_sum = SUM_W'(sum_reg) + SUM_W'(prod_reg);

    assign f_next = cfg.int1_enable ? sat_acc(WIDE_W'(rnd_q16(pair_sum))) : xin;
    assign d_wide = WIDE_W'(rnd_q16(SUM_W'(prod_reg))) + WIDE_W'(f_reg)
                    - WIDE_W'(int1_acc_reg);
    assign s_next = cfg.int2_enable ? sat_acc(WIDE_W'(rnd_q16(pair_sum))) : d_reg;

    always_comb
    begin
        if (!cfg.diff_enable)
            d_next = f_reg;
        else if (first_reg)
            d_next = '0;
        else
            d_next = sat_acc(d_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int1_acc_reg <= '0;
            diff_acc_reg <= '0;
            int2_acc_reg <= '0;
        end
        else if (cmd.load && first)
        begin
            int1_acc_reg <= '0;
            diff_acc_reg <= '0;
            int2_acc_reg <= '0;
        end
        else if (cmd.s_wr)
        begin
            int1_acc_reg <= f_reg;
            diff_acc_reg <= d_reg;
            int2_acc_reg <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= sample;
            first_reg <= first;
        end
        if (cmd.mul_en)
            prod_reg <= mul_out;
        if (cmd.sum_load)
            sum_reg <= prod_reg;
        if (cmd.f_wr)
            f_reg <= f_next;
        if (cmd.d_wr)
            d_reg <= d_next;
        if (cmd.s_wr)
        begin
            integrated_reg     <= f_reg[FRAC+OUT_W-1:FRAC];
            differentiated_reg <= d_reg[FRAC+OUT_W-1:FRAC];
            shaped_reg         <= s_next[FRAC+OUT_W-1:FRAC];
        end
    end

    assign integrated     = integrated_reg;
    assign differentiated = differentiated_reg;
    assign shaped         = shaped_reg;

endmodule

// ----- design/cr_rc_rc_pulse_shaper_core.sv -----
// Top level of the CR-RC-RC pulse shaper: config bank, sequencer and datapath.
// A result beat is valid once its sample beat is accepted and the sequencer has
// stepped through GAIN1, DDEC, DIFF, GAIN2 and the FINAL commit. One sample is
// taken at a time: its five products go through the single 17x32 multiplier in turn.
// The output register holds a result while the next sample is taken; the last
// step waits only if the previous result beat has still not been taken.
// Reset: asynchronous, active low; stage state clears to zero, registers to defaults.
module cr_rc_rc_pulse_shaper_core import crs_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    crs_cfg_if.sink       cfg,
    crs_sample_if.sink    samples,
    crs_result_if.source  results
);

    cfg_t    regs;
    dp_cmd_t cmd;
    logic    in_ready;
    logic    out_valid;

    crs_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    crs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    crs_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (regs),
        .sample         (samples.sample),
        .first          (samples.first),
        .integrated     (results.integrated),
        .differentiated (results.differentiated),
        .shaped         (results.shaped)
    );

    assign samples.ready = in_ready;
    assign results.valid = out_valid;

    // a committed result shows up as an output beat next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.s_wr |=> results.valid)
        else $error("committed result not presented");

    // never overwrite a result beat still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.s_wr |-> (!results.valid || results.ready))
        else $error("pending result overwritten");

    // one sample at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("sample accepted while busy");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.f_wr, cmd.d_wr, cmd.s_wr}))
        else $error("overlapping sequencer steps");

endmodule

// ----- verif/crs_shaper_checker.sv -----
`timescale 1ns / 1ps
// Checker for the pulse shaper: tracks register writes, predicts each result beat and compares.
module crs_shaper_checker import crs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    crs_cfg_if     cfg,
    crs_sample_if  smp,
    crs_result_if  res,
    output int     mismatch_count,
    output int     beats_due
);

    typedef struct packed {
        logic [OUT_W-1:0] integrated;
        logic [OUT_W-1:0] differentiated;
        logic [OUT_W-1:0] shaped;
    } stage_outs_t;

    cfg_t                       shp;
    logic signed [ACC_BITS-1:0] int1_val;
    logic signed [ACC_BITS-1:0] int1_last;
    logic signed [ACC_BITS-1:0] diff_val;
    logic signed [ACC_BITS-1:0] int2_val;
    stage_outs_t                stage_outs_due[$];

    initial
    begin
        mismatch_count = 0;
        beats_due      = 0;
    end

    // Exact c1*a + c2*b in Q0.16, rounded half up to an integer.
    function automatic longint q16_round(input logic [COEF_W-1:0] c1, input longint a,
                                         input logic [COEF_W-1:0] c2, input longint b);
        longint acc;
        acc = longint'(c1) * a + longint'(c2) * b + (longint'(1) <<< (COEF_W - 1));
        return acc >>> COEF_W;
    endfunction

    function automatic logic signed [ACC_BITS-1:0] clamp_acc(input longint v);
        if (v > longint'(ACC_MAX))
            return ACC_MAX;
        if (v < longint'(ACC_MIN))
            return ACC_MIN;
        return ACC_BITS'(v);
    endfunction

    function automatic stage_outs_t shape_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                                 input logic first);
        longint                     xin;
        logic signed [ACC_BITS-1:0] f;
        logic signed [ACC_BITS-1:0] d;
        logic signed [ACC_BITS-1:0] s;
        stage_outs_t                o;
        xin = longint'(x) <<< FRAC;
        if (first)
        begin
            int1_val  = '0;
            int1_last = '0;
            diff_val  = '0;
            int2_val  = '0;
        end
        if (shp.int1_enable)
            f = clamp_acc(q16_round(shp.int1_decay, longint'(int1_val), shp.int1_gain, xin));
        else
            f = clamp_acc(xin);
        // A live differentiator gives zero on the opening sample of a waveform.
        if (!shp.diff_enable)
            d = f;
        else if (first)
            d = '0;
        else
            d = clamp_acc(q16_round(shp.diff_decay, longint'(diff_val), '0, longint'(0))
                          + longint'(f) - longint'(int1_last));
        if (shp.int2_enable)
            s = clamp_acc(q16_round(shp.int2_decay, longint'(int2_val), shp.int2_gain,
                                    longint'(d)));
        else
            s = d;
        int1_val  = f;
        int1_last = f;
        diff_val  = d;
        int2_val  = s;
        o.integrated     = f[ACC_BITS-1:FRAC];
        o.differentiated = d[ACC_BITS-1:FRAC];
        o.shaped         = s[ACC_BITS-1:FRAC];
        return o;
    endfunction

    function automatic void check_field(input string field, input logic [OUT_W-1:0] want,
                                        input logic [OUT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stage_outs_t want;
        if (!rst_n)
        begin
            shp = '{int1_enable: 1'b1, int1_decay: RST_INT1_DECAY, int1_gain: RST_INT1_GAIN,
                    diff_enable: 1'b1, diff_decay: RST_DIFF_DECAY,
                    int2_enable: 1'b1, int2_decay: RST_INT2_DECAY, int2_gain: RST_INT2_GAIN};
            int1_val  = '0;
            int1_last = '0;
            diff_val  = '0;
            int2_val  = '0;
            stage_outs_due.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_idx_t'(cfg.index))
                    REG_INT1_ENABLE: shp.int1_enable = cfg.data[0];
                    REG_INT1_DECAY:  shp.int1_decay  = cfg.data;
                    REG_INT1_GAIN:   shp.int1_gain   = cfg.data;
                    REG_DIFF_ENABLE: shp.diff_enable = cfg.data[0];
                    REG_DIFF_DECAY:  shp.diff_decay  = cfg.data;
                    REG_INT2_ENABLE: shp.int2_enable = cfg.data[0];
                    REG_INT2_DECAY:  shp.int2_decay  = cfg.data;
                    REG_INT2_GAIN:   shp.int2_gain   = cfg.data;
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
            begin
                if (stage_outs_due.size() == 0)
                begin
                    $error("result beat with no sample outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = stage_outs_due.pop_front();
                    check_field("integrated", want.integrated, res.integrated);
                    check_field("differentiated", want.differentiated, res.differentiated);
                    check_field("shaped", want.shaped, res.shaped);
                end
            end
            if (smp.valid && smp.ready)
                stage_outs_due = {stage_outs_due, shape_sample(smp.sample, smp.first)};
        end
        beats_due = stage_outs_due.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the pulse shaper: sample and register stimulus, back-pressure, verdict.
module tb_top;
    import crs_pkg::*;

    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 10;
    localparam int BLOCK_ITEMS     = 35;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   hold_req = 1'b0;
    int   stall_cycles = 0;
    int   mismatch_count;
    int   beats_due;

    crs_cfg_if    cfg_ch();
    crs_sample_if smp_ch();
    crs_result_if res_ch();

    cr_rc_rc_pulse_shaper_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (smp_ch),
        .results (res_ch)
    );

    crs_shaper_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .smp            (smp_ch),
        .res            (res_ch),
        .mismatch_count (mismatch_count),
        .beats_due      (beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_ch.valid && cfg_ch.ready) || (smp_ch.valid && smp_ch.ready)
            || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic first);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            @(negedge clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        smp_ch.first  <= first;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
    endtask

    // Drop the sample stream, drain every outstanding beat and let the pipe go quiet.
    task automatic settle();
        @(negedge clk);
        smp_ch.valid <= 1'b0;
        while (beats_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Enable bits go out with random upper bits, which the block must mask off.
    task automatic apply_setting(input cfg_t c);
        settle();
        write_reg(REG_INT1_ENABLE, {15'($urandom), c.int1_enable});
        write_reg(REG_INT1_DECAY, c.int1_decay);
        write_reg(REG_INT1_GAIN, c.int1_gain);
        write_reg(REG_DIFF_ENABLE, {15'($urandom), c.diff_enable});
        write_reg(REG_DIFF_DECAY, c.diff_decay);
        write_reg(REG_INT2_ENABLE, {15'($urandom), c.int2_enable});
        write_reg(REG_INT2_DECAY, c.int2_decay);
        write_reg(REG_INT2_GAIN, c.int2_gain);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic cfg_t uniform_setting(input logic en, input logic [COEF_W-1:0] coef);
        cfg_t c;
        c.int1_enable = en;
        c.diff_enable = en;
        c.int2_enable = en;
        c.int1_decay  = coef;
        c.int1_gain   = coef;
        c.diff_decay  = coef;
        c.int2_decay  = coef;
        c.int2_gain   = coef;
        return c;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        c.int1_enable = ($urandom_range(3) != 0);
        c.diff_enable = ($urandom_range(3) != 0);
        c.int2_enable = ($urandom_range(3) != 0);
        c.int1_decay  = pick_coef();
        c.int1_gain   = pick_coef();
        c.diff_decay  = pick_coef();
        c.int2_decay  = pick_coef();
        c.int2_gain   = pick_coef();
        return c;
    endfunction

    // Mostly whole waveforms opened by a first flag, with stray single beats as noise.
    task automatic run_block(input int n_items, input cfg_t setting, input bit squeeze);
        int                            sent;
        int                            len;
        int                            style;
        logic signed [SAMPLE_BITS-1:0] base;
        logic signed [SAMPLE_BITS-1:0] level;
        logic signed [SAMPLE_BITS-1:0] s;
        apply_setting(setting);
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 2)
            begin
                send_sample(SAMPLE_BITS'($urandom), 1'($urandom));
                sent++;
                if (squeeze && sent == 5)
                    hold_req = 1'b1;
            end
            else
            begin
                len   = $urandom_range(40, 4);
                style = $urandom_range(3);
                base  = SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
                level = SAMPLE_BITS'($urandom);
                for (int k = 0; k < len; k++)
                begin
                    case (style)
                        0:       s = SAMPLE_BITS'($urandom);
                        1:       s = base + SAMPLE_BITS'($urandom_range(63));
                        2:       s = (k < len / 3) ? base : level;
                        default: s = k[0] ? S_MAX : S_MIN;
                    endcase
                    send_sample(s, k == 0);
                    sent++;
                    if (squeeze && sent == 5)
                        hold_req = 1'b1;
                end
            end
        end
    endtask

    task automatic drive_level(input logic signed [SAMPLE_BITS-1:0] s, input int len);
        for (int k = 0; k < len; k++)
            send_sample(s, k == 0);
    endtask

    initial
    begin
        cfg_t sat_setting;
        rst_n         = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_INT1_ENABLE;
        cfg_ch.data   = '0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        smp_ch.first  = 1'b0;
        tx_idle_pct   = 12;
        rx_idle_pct   = 49;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset coefficients: full-scale steps, sign flips, restarts mid-stream.
        send_sample(S_MAX, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(SAMPLE_BITS'(1), 1'b1);
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b0);

        // All coefficients at full scale.
        apply_setting(uniform_setting(1'b1, '1));
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);

        // Zero gain and decay everywhere.
        apply_setting(uniform_setting(1'b1, '0));
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);

        // Every stage bypassed.
        apply_setting(uniform_setting(1'b0, '1));
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(SAMPLE_BITS'(1), 1'b0);

        run_block(BLOCK_ITEMS, uniform_setting(1'b1, '0), 1'b0);
        repeat (3) run_block(BLOCK_ITEMS, random_setting(), 1'b0);

        tx_idle_pct = 49;
        rx_idle_pct = 12;
        run_block(BLOCK_ITEMS, uniform_setting(1'b0, '1), 1'b0);
        repeat (3) run_block(BLOCK_ITEMS, random_setting(), 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_block(60, random_setting(), 1'b1);

        // Drive both integrators into their clamps with the differentiator bypassed.
        sat_setting             = uniform_setting(1'b1, '1);
        sat_setting.diff_enable = 1'b0;
        apply_setting(sat_setting);
        drive_level(S_MAX, 260);
        drive_level(S_MIN, 40);

        settle();
        if (mismatch_count == 0 && beats_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
design/crs_pkg.sv
design/crs_intf.sv
design/crs_cfg.sv
design/crs_ctrl.sv
design/crs_dp.sv
design/cr_rc_rc_pulse_shaper_core.sv
verif/crs_shaper_checker.sv
verif/tb_top.sv
